// ----- hw/rtl/str_ramp_pkg.sv -----
`timescale 1ns / 1ps

package str_ramp_pkg;

	// item kinds
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_MOVE  = 2'd1;
	localparam logic [1:0] FUNC_LIMIT = 2'd2;

	// stored position codes
	localparam logic [1:0] POS_HOME    = 2'd0;
	localparam logic [1:0] POS_AWAY    = 2'd1;
	localparam logic [1:0] POS_UNKNOWN = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_START_PERIOD = 2'd0;
	localparam logic [1:0] CFG_END_PERIOD   = 2'd1;
	localparam logic [1:0] CFG_TOGGLES      = 2'd2;
	localparam logic [1:0] CFG_TOTAL_UNITS  = 2'd3;

	// register reset values
	localparam logic [15:0] RST_START_PERIOD = 16'd120;
	localparam logic [15:0] RST_END_PERIOD   = 16'd20;
	localparam logic [15:0] RST_TOGGLES      = 16'd100;
	localparam logic [15:0] RST_TOTAL_UNITS  = 16'd200;

	// units of deceleration before the end of a move
	localparam int DECEL_SPAN = 20;

	typedef struct packed {
		logic [15:0] start_period;
		logic [15:0] end_period;
		logic [15:0] toggles_per_unit;
		logic [15:0] total_units;
	} cfg_t;

	typedef struct packed {
		logic        enable;
		logic        direction;
		logic        pulse;
		logic        running;
		logic [1:0]  position;
		logic [15:0] period;
	} ctrl_t;

endpackage

// ----- hw/rtl/str_ramp_cfg.sv -----
`timescale 1ns / 1ps

module str_ramp_cfg import str_ramp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_period     <= RST_START_PERIOD;
			cfg_q.end_period       <= RST_END_PERIOD;
			cfg_q.toggles_per_unit <= RST_TOGGLES;
			cfg_q.total_units      <= RST_TOTAL_UNITS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_PERIOD: cfg_q.start_period     <= cfg_data;
				CFG_END_PERIOD:   cfg_q.end_period       <= cfg_data;
				CFG_TOGGLES:      cfg_q.toggles_per_unit <= cfg_data;
				CFG_TOTAL_UNITS:  cfg_q.total_units      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/str_ramp_update.sv -----
`timescale 1ns / 1ps

module str_ramp_update import str_ramp_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic [1:0]             func,
	input  logic                   move_direction,
	input  logic                   limit_level,
	input  cfg_t                   cfg,
	input  ctrl_t                  ctrl_cur,
	input  logic [COUNT_WIDTH-1:0] tick_cur,
	input  logic [COUNT_WIDTH-1:0] toggle_cur,
	input  logic [COUNT_WIDTH-1:0] unit_cur,
	output ctrl_t                  ctrl_nxt,
	output logic [COUNT_WIDTH-1:0] tick_nxt,
	output logic [COUNT_WIDTH-1:0] toggle_nxt,
	output logic [COUNT_WIDTH-1:0] unit_nxt
);

	// compare width: room for the wider operand plus a sign
	localparam int EW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;

	logic [COUNT_WIDTH-1:0] tick_inc;
	logic [COUNT_WIDTH-1:0] toggle_inc;
	logic [COUNT_WIDTH-1:0] unit_inc;
	logic [EW-1:0]          unit_ext;
	logic [EW-1:0]          accel_lim;
	logic [EW-1:0]          decel_lo;
	logic [EW-1:0]          total_ext;
	logic                   tick_over;
	logic                   toggle_over;
	logic                   in_accel;
	logic                   in_decel;
	logic                   past_total;

	assign tick_inc   = tick_cur + COUNT_WIDTH'(1);
	assign toggle_inc = toggle_cur + COUNT_WIDTH'(1);
	assign unit_inc   = unit_cur + COUNT_WIDTH'(1);

	assign unit_ext  = EW'(unit_inc);
	assign total_ext = EW'(cfg.total_units);
	assign accel_lim = EW'(cfg.start_period) - EW'(cfg.end_period);
	assign decel_lo  = total_ext - EW'(DECEL_SPAN);

	assign tick_over   = EW'(tick_inc) > EW'(ctrl_cur.period);
	assign toggle_over = EW'(toggle_inc) > EW'(cfg.toggles_per_unit);
	assign in_accel    = $signed(unit_ext) < $signed(accel_lim);
	assign in_decel    = ($signed(unit_ext) > $signed(decel_lo))
		&& ($signed(unit_ext) < $signed(total_ext));
	assign past_total  = unit_ext > total_ext;

	// next state for one request
	always_comb begin
		ctrl_nxt   = ctrl_cur;
		tick_nxt   = tick_cur;
		toggle_nxt = toggle_cur;
		unit_nxt   = unit_cur;
		case (func)
			FUNC_TICK: begin
				if (ctrl_cur.running) begin
					if (!tick_over) begin
						tick_nxt = tick_inc;
					end else begin
						tick_nxt       = '0;
						ctrl_nxt.pulse = ~ctrl_cur.pulse;
						if (!toggle_over) begin
							toggle_nxt = toggle_inc;
						end else begin
							toggle_nxt = '0;
							unit_nxt   = unit_inc;
							// speed profile step per progress unit
							if (in_accel) begin
								if (ctrl_cur.period > cfg.end_period) begin
									ctrl_nxt.period = ctrl_cur.period - 16'd1;
								end
							end else if (in_decel) begin
								if (ctrl_cur.period < cfg.start_period) begin
									ctrl_nxt.period = ctrl_cur.period + 16'd1;
								end
							end else if (past_total) begin
								unit_nxt         = '0;
								ctrl_nxt.enable  = 1'b0;
								ctrl_nxt.period  = cfg.start_period;
								ctrl_nxt.running = 1'b0;
							end
						end
					end
				end
			end
			FUNC_MOVE: begin
				if (!ctrl_cur.running && ({1'b0, move_direction} != ctrl_cur.position)) begin
					ctrl_nxt.direction = move_direction;
					ctrl_nxt.enable    = 1'b1;
					ctrl_nxt.period    = cfg.start_period;
					ctrl_nxt.position  = {1'b0, move_direction};
					ctrl_nxt.running   = 1'b1;
				end
			end
			FUNC_LIMIT: begin
				if (!ctrl_cur.direction && !limit_level) begin
					unit_nxt          = '0;
					ctrl_nxt.enable   = 1'b0;
					ctrl_nxt.period   = cfg.start_period;
					ctrl_nxt.running  = 1'b0;
					ctrl_nxt.position = POS_HOME;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/stepper_trapezoid_ramp_core.sv -----
`timescale 1ns / 1ps

// channel   handshake             payload
// in        in_valid / in_ready   func, move_direction, limit_level
// out       out_valid / out_ready motor_enable, motor_direction, step_pulse,
//                                 busy_res, at_position, current_period
// cfg       cfg_we                cfg_index, cfg_data
//
// a request is taken into an input register, and the next state and its
// result are formed into the result register as the request leaves it
// one request per cycle sustained while the result register is not stalled
// reset clears the motion state and loads the register reset values
// a stalled result register holds the input register, and in_ready drops
// only when both are full

module stepper_trapezoid_ramp_core import str_ramp_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        move_direction,
	input  logic        limit_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        motor_enable,
	output logic        motor_direction,
	output logic        step_pulse,
	output logic        busy_res,
	output logic [1:0]  at_position,
	output logic [15:0] current_period,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t                   cfg;
	ctrl_t                  ctrl_q;
	ctrl_t                  ctrl_nxt;
	logic [COUNT_WIDTH-1:0] tick_q;
	logic [COUNT_WIDTH-1:0] toggle_q;
	logic [COUNT_WIDTH-1:0] unit_q;
	logic [COUNT_WIDTH-1:0] tick_nxt;
	logic [COUNT_WIDTH-1:0] toggle_nxt;
	logic [COUNT_WIDTH-1:0] unit_nxt;

	logic       valid_s1;
	logic [1:0] func_s1;
	logic       dir_s1;
	logic       level_s1;
	logic       valid_s2;
	ctrl_t      res_s2;
	logic       advance;

	str_ramp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	str_ramp_update #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_update (
		.func           (func_s1),
		.move_direction (dir_s1),
		.limit_level    (level_s1),
		.cfg            (cfg),
		.ctrl_cur       (ctrl_q),
		.tick_cur       (tick_q),
		.toggle_cur     (toggle_q),
		.unit_cur       (unit_q),
		.ctrl_nxt       (ctrl_nxt),
		.tick_nxt       (tick_nxt),
		.toggle_nxt     (toggle_nxt),
		.unit_nxt       (unit_nxt)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1  <= func;
			dir_s1   <= move_direction;
			level_s1 <= limit_level;
		end
	end

	// motion state, updated as a request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.enable    <= 1'b0;
			ctrl_q.direction <= 1'b0;
			ctrl_q.pulse     <= 1'b0;
			ctrl_q.running   <= 1'b0;
			ctrl_q.position  <= POS_UNKNOWN;
			ctrl_q.period    <= RST_START_PERIOD;
			tick_q           <= '0;
			toggle_q         <= '0;
			unit_q           <= '0;
		end else if (valid_s1 && advance) begin
			ctrl_q   <= ctrl_nxt;
			tick_q   <= tick_nxt;
			toggle_q <= toggle_nxt;
			unit_q   <= unit_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= ctrl_nxt;
		end
	end

	assign out_valid       = valid_s2;
	assign motor_enable    = res_s2.enable;
	assign motor_direction = res_s2.direction;
	assign step_pulse      = res_s2.pulse;
	assign busy_res        = res_s2.running;
	assign at_position     = res_s2.position;
	assign current_period  = res_s2.period;

`ifndef SYNTHESIS
	// driver is powered exactly while a move runs
	a_enable_running: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.enable == ctrl_q.running)
		else $error("enable and running disagree");

	// position code 3 never appears
	a_position_code: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_q.position != 2'd3)
		else $error("invalid position code");

	// an empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled with free result register");

	// a request in stage 1 reaches an empty result register next cycle
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("request lost between stages");
`endif

endmodule
